>>> sv/etbt_pkg.sv
`timescale 1ns / 1ps
// Package for the extent table block translate design.
// Table size, segment record, operation and status codes, FSM states.
// No dependencies.
package etbt_pkg;

  localparam int MaxSegments = 16;
  localparam int SegIdxW     = (MaxSegments > 1) ? $clog2(MaxSegments) : 1;
  localparam int CountW      = $clog2(MaxSegments + 1);
  localparam int BlockW      = 32;
  localparam int PhysW       = 33;
  localparam int TotalW      = 36;

  typedef enum logic [1:0] {
    OP_APPEND    = 2'd0,
    OP_CLEAR     = 2'd1,
    OP_TRANSLATE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [BlockW-1:0] log_start;
    logic [BlockW-1:0] length;
    logic [BlockW-1:0] physical_start;
  } seg_t;

  typedef struct packed {
    logic             hit;
    logic [PhysW-1:0] phys;
  } match_t;

endpackage

>>> sv/etbt_match.sv
`timescale 1ns / 1ps
// Range check of one stored segment against a query block.
// Depends on etbt_pkg.
module etbt_match
  import etbt_pkg::*;
(
  input  logic [BlockW-1:0] query_i,
  input  seg_t              seg_i,
  output match_t            match_o
);

  logic [BlockW:0]   range_end;
  logic [BlockW-1:0] offset;

  always_comb begin
    range_end     = {1'b0, seg_i.log_start} + {1'b0, seg_i.length};
    offset        = query_i - seg_i.log_start;
    match_o.hit   = (query_i >= seg_i.log_start) && ({1'b0, query_i} < range_end);
    match_o.phys  = {1'b0, seg_i.physical_start} + {1'b0, offset};
  end

endmodule

>>> sv/extent_table_block_translate.sv
`timescale 1ns / 1ps
// Top level of the extent table: segment memory, scan sequencer, result register.
// Depends on etbt_pkg and etbt_match.
// Each request appends a segment, clears the table or translates a logical
// block; exactly one result follows each request. Append, clear and an unknown
// operation set the result when accepted and move straight to the response
// state. A translate reads the segment memory one entry per cycle in append
// order and stops at the first hit or once every stored segment was read; the
// segment memory has a single read port. The response state moves the result
// to the output register once the previous result has been taken.
// A new request is taken while a finished result still waits on the output.
module extent_table_block_translate
  import etbt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        operation_i,
  input  logic [BlockW-1:0] new_log_start_i,
  input  logic [BlockW-1:0] new_length_i,
  input  logic [BlockW-1:0] new_physical_start_i,
  input  logic [BlockW-1:0] query_block_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        status_o,
  output logic [PhysW-1:0]  phys_block_o,
  output logic [TotalW-1:0] total_blocks_o
);

  state_e state_q, state_d;

  logic [CountW-1:0] used_q, used_d;
  logic [TotalW-1:0] total_q, total_d;
  logic [BlockW-1:0] query_q, query_d;
  logic [CountW-1:0] scan_idx_q, scan_idx_d;
  logic              rd_vld_q, rd_vld_d;
  status_e           res_status_q, res_status_d;
  logic [PhysW-1:0]  res_phys_q, res_phys_d;

  logic              out_valid_q, out_valid_d;
  status_e           out_status_q;
  logic [PhysW-1:0]  out_phys_q;
  logic [TotalW-1:0] out_total_q;

  seg_t              mem_q [MaxSegments];
  seg_t              rdata_q;
  logic              mem_we;
  logic              mem_re;
  seg_t              wdata;

  logic              accept;
  logic              issue;
  logic              out_load;
  logic [TotalW:0]   total_sum;
  match_t            match;
  op_e               op;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign issue      = (scan_idx_q < used_q);
  assign out_load   = (state_q == S_RESP) && (!out_valid_q || !out_stall_i);
  assign total_sum  = {1'b0, total_q} + {{(TotalW - BlockW + 1){1'b0}}, new_length_i};
  assign op         = op_e'(operation_i);

  assign wdata.log_start      = new_log_start_i;
  assign wdata.length         = new_length_i;
  assign wdata.physical_start = new_physical_start_i;

  etbt_match u_match (
    .query_i (query_q),
    .seg_i   (rdata_q),
    .match_o (match)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = (op == OP_TRANSLATE) ? S_SCAN : S_RESP;
        end
      end
      S_SCAN: begin
        if ((rd_vld_q && match.hit) || !issue) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath updates
  always_comb begin
    used_d       = used_q;
    total_d      = total_q;
    query_d      = query_q;
    scan_idx_d   = scan_idx_q;
    rd_vld_d     = 1'b0;
    res_status_d = res_status_q;
    res_phys_d   = res_phys_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_status_d = STAT_OK;
          res_phys_d   = '0;
          case (op)
            OP_APPEND: begin
              if (used_q < CountW'(MaxSegments)) begin
                mem_we  = 1'b1;
                used_d  = used_q + CountW'(1);
                total_d = total_sum[TotalW] ? {TotalW{1'b1}} : total_sum[TotalW-1:0];
              end else begin
                res_status_d = STAT_FULL;
              end
            end
            OP_CLEAR: begin
              used_d  = '0;
              total_d = '0;
            end
            OP_TRANSLATE: begin
              query_d    = query_block_i;
              scan_idx_d = '0;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (rd_vld_q && match.hit) begin
          res_status_d = STAT_OK;
          res_phys_d   = match.phys;
        end else if (!issue) begin
          res_status_d = STAT_NOT_FOUND;
          res_phys_d   = '0;
        end else begin
          mem_re     = 1'b1;
          rd_vld_d   = 1'b1;
          scan_idx_d = scan_idx_q + CountW'(1);
        end
      end
      S_RESP: ;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      total_q     <= '0;
      scan_idx_q  <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      total_q     <= total_d;
      scan_idx_q  <= scan_idx_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    query_q      <= query_d;
    res_status_q <= res_status_d;
    res_phys_q   <= res_phys_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_phys_q   <= res_phys_q;
      out_total_q  <= total_q;
    end
  end

  // segment memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[used_q[SegIdxW-1:0]] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[scan_idx_q[SegIdxW-1:0]];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign phys_block_o   = out_phys_q;
  assign total_blocks_o = out_total_q;

endmodule

>>> tb/sv/tb_extent_table_block_translate.sv
`timescale 1ns / 1ps
// Testbench for extent_table_block_translate: directed and random append, clear and
// translate requests, checked against an in-bench extent table with saturating total.
// Depends on etbt_pkg and the extent_table_block_translate RTL.
module tb_extent_table_block_translate;
  import etbt_pkg::*;

  localparam logic [1:0] OpUnknown   = 2'd3;
  localparam int         CycleLimit  = 600000;
  localparam int         HoldCycles  = 400;
  localparam int         DrainCycles = MaxSegments + 16;
  localparam int         PhaseItems  = 250;

  typedef struct packed {
    status_e           status;
    logic [PhysW-1:0]  phys;
    logic [TotalW-1:0] total;
  } xlate_result_t;

  class extent_scoreboard;
    logic [BlockW-1:0] seg_start[MaxSegments];
    logic [BlockW-1:0] seg_len[MaxSegments];
    logic [BlockW-1:0] seg_phys[MaxSegments];
    int unsigned       seg_count;
    logic [TotalW-1:0] blocks_total;
    xlate_result_t     expected_q[$];
    int                errors;

    function new();
      seg_count    = 0;
      blocks_total = '0;
      errors       = 0;
    endfunction

    function void note_request(logic [1:0] op, logic [BlockW-1:0] lstart,
                               logic [BlockW-1:0] len, logic [BlockW-1:0] pstart,
                               logic [BlockW-1:0] query);
      xlate_result_t     res;
      logic [TotalW:0]   sum;
      logic [PhysW-1:0]  lo;
      logic [PhysW-1:0]  hi;
      logic [PhysW-1:0]  q;
      bit                hit;
      res.status = STAT_OK;
      res.phys   = '0;
      hit        = 1'b0;
      if (op == OP_APPEND) begin
        if (seg_count < MaxSegments) begin
          seg_start[seg_count] = lstart;
          seg_len[seg_count]   = len;
          seg_phys[seg_count]  = pstart;
          seg_count++;
          sum = {1'b0, blocks_total} + {{(TotalW + 1 - BlockW){1'b0}}, len};
          blocks_total = sum[TotalW] ? {TotalW{1'b1}} : sum[TotalW-1:0];
        end else begin
          res.status = STAT_FULL;
        end
      end else if (op == OP_CLEAR) begin
        seg_count    = 0;
        blocks_total = '0;
      end else if (op == OP_TRANSLATE) begin
        q = {1'b0, query};
        for (int i = 0; i < seg_count; i++) begin
          lo = {1'b0, seg_start[i]};
          hi = lo + {1'b0, seg_len[i]};
          if (!hit && q >= lo && q < hi) begin
            res.phys = {1'b0, seg_phys[i]} + (q - lo);
            hit      = 1'b1;
          end
        end
        if (!hit) res.status = STAT_NOT_FOUND;
      end
      res.total = blocks_total;
      expected_q.push_back(res);
    endfunction

    function void check_result(logic [1:0] status, logic [PhysW-1:0] phys,
                               logic [TotalW-1:0] total);
      xlate_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result status %0d phys %h total %h",
                 $time, status, phys, total);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status);
          errors++;
        end
        if (phys !== want.phys) begin
          $display("%0t: phys_block expected %h actual %h", $time, want.phys, phys);
          errors++;
        end
        if (total !== want.total) begin
          $display("%0t: total_blocks expected %h actual %h", $time, want.total, total);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni               = 1'b0;
  logic              in_valid_i           = 1'b0;
  logic              in_stall_o;
  logic [1:0]        operation_i          = '0;
  logic [BlockW-1:0] new_log_start_i      = '0;
  logic [BlockW-1:0] new_length_i         = '0;
  logic [BlockW-1:0] new_physical_start_i = '0;
  logic [BlockW-1:0] query_block_i        = '0;
  logic              out_valid_o;
  logic              out_stall_i          = 1'b0;
  logic [1:0]        status_o;
  logic [PhysW-1:0]  phys_block_o;
  logic [TotalW-1:0] total_blocks_o;

  extent_scoreboard sb = new();

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_req      = 0;
  int hold_taken    = 0;
  int hold_left     = 0;
  int requests_sent = 0;
  int cycle_count   = 0;

  extent_table_block_translate dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .operation_i,
    .new_log_start_i,
    .new_length_i,
    .new_physical_start_i,
    .query_block_i,
    .out_valid_o,
    .out_stall_i,
    .status_o,
    .phys_block_o,
    .total_blocks_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL extent_table_block_translate");
      $finish;
    end
  end

  // long hold-off runs in its own counter so the sender keeps pushing requests
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left   = hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (hold_taken != hold_req) begin
      hold_taken  = hold_req;
      hold_left   = HoldCycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(status_o, phys_block_o, total_blocks_o);
  end

  task automatic send_req(input logic [1:0] op, input logic [BlockW-1:0] lstart,
                          input logic [BlockW-1:0] len, input logic [BlockW-1:0] pstart,
                          input logic [BlockW-1:0] query);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i           <= 1'b1;
    operation_i          <= op;
    new_log_start_i      <= lstart;
    new_length_i         <= len;
    new_physical_start_i <= pstart;
    query_block_i        <= query;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(op, lstart, len, pstart, query);
    requests_sent++;
  endtask

  function automatic logic [BlockW-1:0] pick_value();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return $urandom_range(0, 63);
      2:       return 32'hFFFF_FFFF - $urandom_range(0, 63);
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic logic [BlockW-1:0] pick_length();
    if ($urandom_range(11) == 0) return '0;
    return pick_value();
  endfunction

  // usually clear, fill with extents, then translate mostly inside or at the edges of them
  task automatic run_sequence();
    logic [BlockW-1:0] ls_a[MaxSegments];
    logic [BlockW-1:0] len_a[MaxSegments];
    logic [BlockW-1:0] ls;
    logic [BlockW-1:0] len;
    logic [BlockW-1:0] ps;
    logic [BlockW-1:0] q;
    int                n;
    int                m;
    int                k;
    int                stored;
    if ($urandom_range(9) != 0)
      send_req(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
    n = ($urandom_range(9) == 0) ? $urandom_range(MaxSegments + 1, MaxSegments + 3)
                                 : $urandom_range(1, MaxSegments);
    for (int i = 0; i < n; i++) begin
      ls  = pick_value();
      len = pick_length();
      ps  = pick_value();
      if (i < MaxSegments) begin
        ls_a[i]  = ls;
        len_a[i] = len;
      end
      send_req(OP_APPEND, ls, len, ps, $urandom);
      if ($urandom_range(7) == 0)
        send_req(OP_TRANSLATE, $urandom, $urandom, $urandom, ls + $urandom_range(0, 3));
      if ($urandom_range(39) == 0)
        send_req(OpUnknown, $urandom, $urandom, $urandom, $urandom);
    end
    stored = (n < MaxSegments) ? n : MaxSegments;
    m = $urandom_range(2, 8);
    for (int j = 0; j < m; j++) begin
      k = $urandom_range(0, stored - 1);
      case ($urandom_range(9))
        6:       q = ls_a[k] + len_a[k] - 1;
        7:       q = ls_a[k] + len_a[k];
        8:       q = ls_a[k] - 1;
        9:       q = $urandom;
        default: q = (len_a[k] != 0) ? ls_a[k] + ($urandom % len_a[k]) : ls_a[k];
      endcase
      send_req(OP_TRANSLATE, $urandom, $urandom, $urandom, q);
    end
  endtask

  task automatic run_phase(input int idle, input int stall, input bit hold);
    int goal;
    send_idle_pct = idle;
    stall_pct     = stall;
    if (hold) hold_req++;
    goal = requests_sent + PhaseItems;
    while (requests_sent < goal) run_sequence();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_req(OP_TRANSLATE, '0, '0, '0, '0);
    send_req(OpUnknown, '1, '1, '1, '1);
    send_req(OP_APPEND, '0, '0, '0, '1);
    send_req(OP_TRANSLATE, '0, '0, '0, '0);
    send_req(OP_APPEND, '1, '1, '1, '0);
    send_req(OP_TRANSLATE, '0, '0, '0, 32'hFFFF_FFFF);
    send_req(OP_APPEND, 32'd10, 32'd5, 32'd100, '0);
    send_req(OP_APPEND, 32'd12, 32'd10, 32'd500, '0);
    send_req(OP_TRANSLATE, '0, '0, '0, 32'd12);
    send_req(OP_TRANSLATE, '0, '0, '0, 32'd14);
    send_req(OP_TRANSLATE, '0, '0, '0, 32'd15);
    send_req(OP_TRANSLATE, '0, '0, '0, 32'd9);
    for (int i = 4; i < MaxSegments; i++)
      send_req(OP_APPEND, '0, '1, '1, '0);
    send_req(OP_APPEND, 32'd1, 32'd1, 32'd1, '0);
    send_req(OP_TRANSLATE, '0, '0, '0, 32'hFFFF_FFFE);
    send_req(OP_TRANSLATE, '0, '0, '0, 32'd21);
    send_req(OP_CLEAR, '1, '1, '1, '1);
    send_req(OP_TRANSLATE, '0, '0, '0, 32'd12);

    run_phase(0, 0, 1'b1);
    run_phase(78, 0, 1'b0);
    run_phase(0, 78, 1'b0);
    run_phase(27, 27, 1'b1);
    run_phase(0, 0, 1'b0);

    in_valid_i <= 1'b0;
    stall_pct = 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("PASS extent_table_block_translate");
    else
      $display("FAIL extent_table_block_translate");
    $finish;
  end

endmodule
